### hw/rtl/assert_macros.svh
// assertion macros for the rtl, included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

### hw/rtl/aes_pkg.sv
// types, constants and byte functions of the aes block
package aes_pkg;
   localparam int RkDepth = 60;
   localparam int RkAddrWidth = 6;
   localparam logic [2:0] CSR_KEY0 = 3'd0;
   localparam logic [2:0] CSR_KEY1 = 3'd1;
   localparam logic [2:0] CSR_KEY2 = 3'd2;
   localparam logic [2:0] CSR_KEY3 = 3'd3;
   localparam logic [2:0] CSR_KLEN = 3'd4;
   localparam logic [1:0] KLEN_128 = 2'd0;
   localparam logic [1:0] KLEN_192 = 2'd1;

   // controller to datapath
   typedef struct packed {
      logic       exp_load;   // load key words, start schedule
      logic       exp_step;   // produce one schedule word
      logic       blk_load;   // capture block and direction of the accepted transaction
      logic       rk_read;    // issue round key read
      logic       round_en;   // apply a round using registered round key
      logic       first;      // whitening only
      logic       last;       // final round (no mixing)
      logic [RkAddrWidth-1:0] rk_addr;
   } aes_cmd_type;

   typedef logic [127:0] aes_state_type;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      logic [7:0] x;
      p = 8'h00;
      x = a;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) p = p ^ x;
         x = xtime(x);
      end
      gmul = p;
   endfunction

   function automatic logic [7:0] ginv(input logic [7:0] x);
      logic [7:0] r;
      logic [7:0] base;
      r = 8'h01;
      base = x;
      for (int k = 0; k < 8; k++) begin
         if (k != 0) r = gmul(r, base);
         base = gmul(base, base);
      end
      ginv = r;
   endfunction

   function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
      rotl8 = (v << n) | (v >> (8 - n));
   endfunction

   function automatic logic [7:0] sbox_calc(input logic [7:0] x);
      logic [7:0] b;
      b = ginv(x);
      sbox_calc = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
   endfunction

   function automatic logic [7:0] inv_sbox_calc(input logic [7:0] y);
      inv_sbox_calc = ginv(rotl8(y, 1) ^ rotl8(y, 3) ^ rotl8(y, 6) ^ 8'h05);
   endfunction

   typedef logic [7:0] byte_tab_type [256];

   function automatic byte_tab_type make_sbox(input logic inv);
      byte_tab_type t;
      for (int i = 0; i < 256; i++)
         t[i] = inv ? inv_sbox_calc(8'(i)) : sbox_calc(8'(i));
      return t;
   endfunction

   localparam byte_tab_type SBOX = make_sbox(1'b0);
   localparam byte_tab_type INV_SBOX = make_sbox(1'b1);

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction
endpackage

### hw/rtl/aes_ctrl.sv
// sequencer for key expansion and the round loop
module aes_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 func,
   input  logic                 keys_ready,
   input  logic [1:0]           key_length,
   output logic                 busy,
   output logic                 done,
   output aes_pkg::aes_cmd_type cmd
);
   import aes_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXP  = 3'd1;
   localparam logic [2:0] ST_LOAD = 3'd2;
   localparam logic [2:0] ST_RND  = 3'd3;

   logic [2:0] state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [3:0] rnd_ff, rnd_in;
   logic       dec_ff, dec_in;
   logic       pend_ff, pend_in;
   logic       done_ff, done_in;
   logic [3:0] nr;
   logic [5:0] total;

   always_comb begin
      case (key_length)
         KLEN_128: nr = 4'd10;
         KLEN_192: nr = 4'd12;
         default:  nr = 4'd14;
      endcase
      total = {nr, 2'b00} + 6'd4;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rnd_in   = rnd_ff;
      dec_in   = dec_ff;
      pend_in  = pend_ff;
      done_in  = 1'b0;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               dec_in  = func;
               pend_in = 1'b1;
               cmd.blk_load = 1'b1;
               if (!keys_ready) begin
                  cmd.exp_load = 1'b1;
                  cnt_in   = (key_length == KLEN_128) ? 6'd4 :
                             (key_length == KLEN_192) ? 6'd6 : 6'd8;
                  state_in = ST_EXP;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_EXP: begin
            cmd.exp_step = 1'b1;
            cmd.rk_addr  = cnt_ff;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff + 6'd1 == total) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.rk_read  = 1'b1;
            rnd_in  = 4'd0;
            cnt_in  = 6'd0;
            cmd.rk_addr = {(dec_ff ? nr : 4'd0), 2'b00};
            state_in = ST_RND;
         end
         ST_RND: begin
            // four key words are read, then the round is applied
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff[1:0] != 2'd3) begin
               cmd.rk_read = 1'b1;
               cmd.rk_addr = {(dec_ff ? nr - rnd_ff : rnd_ff), cnt_in[1:0]};
            end else begin
               cmd.round_en = 1'b1;
               cmd.first = (rnd_ff == 4'd0);
               cmd.last  = (rnd_ff == nr);
               rnd_in = rnd_ff + 4'd1;
               if (rnd_ff == nr) begin
                  state_in = ST_IDLE;
                  pend_in  = 1'b0;
                  done_in  = 1'b1;
               end else begin
                  // first key word of the next round
                  cmd.rk_read = 1'b1;
                  cmd.rk_addr = {(dec_ff ? nr - (rnd_ff + 4'd1) : rnd_ff + 4'd1), 2'b00};
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         rnd_ff   <= '0;
         dec_ff   <= 1'b0;
         pend_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rnd_ff   <= rnd_in;
         dec_ff   <= dec_in;
         pend_ff  <= pend_in;
         done_ff  <= done_in;
      end
   end

   assign busy = pend_ff;
   assign done = done_ff;
endmodule

### hw/rtl/aes_datapath.sv
// key store, schedule generator and round datapath
module aes_datapath (
   input  logic                 clock,
   input  logic                 func,
   input  logic [63:0]          block_hi,
   input  logic [63:0]          block_lo,
   input  logic [255:0]         key,
   input  logic [1:0]           key_length,
   input  aes_pkg::aes_cmd_type cmd,
   output logic [127:0]         result
);
   import aes_pkg::*;

   logic [31:0]  rk_mem [RkDepth];
   logic [31:0]  rk_rd_ff;
   logic [127:0] rk_ff;
   logic [255:0] win_ff, win_in;   // last nk schedule words, newest in low bits
   logic [7:0]   rc_ff, rc_in;
   logic [3:0]   pos_ff, pos_in;   // i mod nk
   logic [3:0]   nk;
   logic         dec_ff;
   aes_state_type st_ff, st_in;
   logic [31:0]  prev, oldw, t, neww;
   logic [5:0]   wr_addr;
   logic         wr_en;
   logic [31:0]  wr_data;

   always_comb begin
      case (key_length)
         KLEN_128: nk = 4'd4;
         KLEN_192: nk = 4'd6;
         default:  nk = 4'd8;
      endcase
   end

   // schedule step: w[i] = w[i-nk] ^ f(w[i-1])
   always_comb begin
      prev = win_ff[31:0];
      case (nk)
         4'd4:    oldw = win_ff[127:96];
         4'd6:    oldw = win_ff[191:160];
         default: oldw = win_ff[255:224];
      endcase
      t = prev;
      rc_in = rc_ff;
      if (pos_ff == 4'd0) begin
         t = sub_word({prev[23:0], prev[31:24]}) ^ {rc_ff, 24'h0};
         rc_in = xtime(rc_ff);
      end else if (nk == 4'd8 && pos_ff == 4'd4) begin
         t = sub_word(prev);
      end
      neww = oldw ^ t;
      win_in = {win_ff[223:0], neww};
      pos_in = (pos_ff + 4'd1 == nk) ? 4'd0 : pos_ff + 4'd1;
   end

   // the store takes the generated words, one per expansion cycle
   always_comb begin
      wr_en   = cmd.exp_step;
      wr_addr = cmd.rk_addr;
      wr_data = neww;
   end

   always_ff @(posedge clock) begin
      if (cmd.exp_load) begin
         for (int i = 0; i < 8; i++)
            win_ff[32*i +: 32] <= (i < 32'(nk)) ? key[255 - 32*(32'(nk) - 1 - i) -: 32]
                                                : 32'h0;
         rc_ff  <= 8'h01;
         pos_ff <= 4'd0;
      end else if (cmd.exp_step) begin
         win_ff <= win_in;
         rc_ff  <= rc_in;
         pos_ff <= pos_in;
      end
   end

   // the first nk words come from a copy of the key taken at expansion
   logic [31:0] kw_mem [8];
   always_ff @(posedge clock) begin
      if (cmd.exp_load)
         for (int i = 0; i < 8; i++) kw_mem[i] <= key[255 - 32*i -: 32];
   end

   always_ff @(posedge clock) begin
      if (wr_en) rk_mem[wr_addr] <= wr_data;
      if (cmd.rk_read) begin
         if (cmd.rk_addr < 6'(nk)) rk_rd_ff <= kw_mem[cmd.rk_addr[2:0]];
         else rk_rd_ff <= rk_mem[cmd.rk_addr];
      end
   end

   // gather four words of a round key
   always_ff @(posedge clock) begin
      if (cmd.rk_read || cmd.round_en) rk_ff <= {rk_ff[95:0], rk_rd_ff};
   end

   function automatic aes_state_type shift_sub(input aes_state_type s, input logic inv);
      aes_state_type o;
      int src;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) begin
            src = inv ? ((c + 4 - r) & 3) : ((c + r) & 3);
            o[127 - 8*(4*c + r) -: 8] = inv ? INV_SBOX[s[127 - 8*(4*src + r) -: 8]]
                                            : SBOX[s[127 - 8*(4*src + r) -: 8]];
         end
      return o;
   endfunction

   function automatic aes_state_type mix(input aes_state_type s, input logic inv);
      aes_state_type o;
      logic [7:0] a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127 - 32*c -: 8];
         a1 = s[119 - 32*c -: 8];
         a2 = s[111 - 32*c -: 8];
         a3 = s[103 - 32*c -: 8];
         if (!inv) begin
            o[127 - 32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            o[119 - 32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            o[111 - 32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            o[103 - 32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
         end else begin
            o[127 - 32*c -: 8] = gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13)
                                 ^ gmul(a3, 8'd9);
            o[119 - 32*c -: 8] = gmul(a0, 8'd9) ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11)
                                 ^ gmul(a3, 8'd13);
            o[111 - 32*c -: 8] = gmul(a0, 8'd13) ^ gmul(a1, 8'd9) ^ gmul(a2, 8'd14)
                                 ^ gmul(a3, 8'd11);
            o[103 - 32*c -: 8] = gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9)
                                 ^ gmul(a3, 8'd14);
         end
      end
      return o;
   endfunction

   logic [127:0] key_now, ss;
   assign key_now = {rk_ff[95:0], rk_rd_ff};

   always_comb begin
      ss = shift_sub(st_ff, dec_ff);
      if (cmd.first) st_in = st_ff ^ key_now;
      else if (!dec_ff) st_in = cmd.last ? ss ^ key_now : mix(ss, 1'b0) ^ key_now;
      else st_in = cmd.last ? ss ^ key_now : mix(ss ^ key_now, 1'b1);
   end

   always_ff @(posedge clock) begin
      if (cmd.blk_load) begin
         st_ff  <= {block_hi, block_lo};
         dec_ff <= func;
      end else if (cmd.round_en) begin
         st_ff <= st_in;
      end
   end

   assign result = st_ff;
endmodule

### hw/rtl/aes_block_cipher.sv
// aes block cipher top level: registers, controller and datapath
// a block passes the load state and Nr+1 rounds before rsp_valid, Nr = 10, 12 or 14;
// the first block after reset or a key change also runs the key expansion first
// no start is taken while busy; the next start is taken in the rsp_valid cycle; the
// block rate is set by the single round-key read port; results cannot stall
// synchronous active-high reset clears control state and key registers
`include "assert_macros.svh"
module aes_block_cipher (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_func,
   input  logic [63:0] req_block_hi,
   input  logic [63:0] req_block_lo,
   output logic        rsp_valid,
   output logic [63:0] rsp_result_hi,
   output logic [63:0] rsp_result_lo,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   import aes_pkg::*;

   logic [63:0] key_ff [4];
   logic [1:0]  klen_ff;
   logic        ready_ff;
   logic [127:0] result;
   aes_cmd_type cmd;
   logic        accept;

   assign csr_ready = 1'b1;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
         klen_ff  <= KLEN_128;
         ready_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_KEY0: begin key_ff[0] <= csr_data; ready_ff <= 1'b0; end
               CSR_KEY1: begin key_ff[1] <= csr_data; ready_ff <= 1'b0; end
               CSR_KEY2: begin key_ff[2] <= csr_data; ready_ff <= 1'b0; end
               CSR_KEY3: begin key_ff[3] <= csr_data; ready_ff <= 1'b0; end
               CSR_KLEN: begin klen_ff <= csr_data[1:0]; ready_ff <= 1'b0; end
               default: ;
            endcase
         end else if (accept) begin
            ready_ff <= 1'b1;
         end
      end
   end

   aes_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .func(req_func),
      .keys_ready(ready_ff), .key_length(klen_ff), .busy(busy),
      .done(rsp_valid), .cmd(cmd)
   );

   aes_datapath u_dp (
      .clock(clock), .func(req_func), .block_hi(req_block_hi),
      .block_lo(req_block_lo), .key({key_ff[0], key_ff[1], key_ff[2], key_ff[3]}),
      .key_length(klen_ff), .cmd(cmd), .result(result)
   );

   assign rsp_result_hi = result[127:64];
   assign rsp_result_lo = result[63:0];

   `ASSERT_NEXT(a_busy_after_start, clock, reset, accept, busy)
   `ASSERT_IMPLIES(a_idle_on_done, clock, reset, rsp_valid, !busy)
   `ASSERT_NEXT(a_single_done, clock, reset, rsp_valid, !rsp_valid)
endmodule

### tb/tb_top.sv
// testbench for the aes block cipher: directed and random blocks against a local model
`timescale 1ns / 1ps
module tb_top;
   import aes_pkg::*;

   localparam logic FUNC_ENC = 1'b0;
   localparam logic FUNC_DEC = 1'b1;
   localparam logic [1:0] KLEN_256 = 2'd2;
   localparam logic [1:0] KLEN_SAT = 2'd3;
   localparam int WatchLimit = 20000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_func;
   logic [63:0] req_block_hi;
   logic [63:0] req_block_lo;
   logic        rsp_valid;
   logic [63:0] rsp_result_hi;
   logic [63:0] rsp_result_lo;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [63:0] csr_data;

   aes_block_cipher i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_block_hi(req_block_hi), .req_block_lo(req_block_lo),
      .rsp_valid(rsp_valid), .rsp_result_hi(rsp_result_hi), .rsp_result_lo(rsp_result_lo),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // local copy of key registers and schedule
   logic [63:0]  key_reg [4];
   logic [1:0]   klen_reg;
   logic [31:0]  sched [60];
   bit           sched_valid;
   logic [127:0] expected_blocks [$];
   int           mismatches;
   int           idle_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] gf_dbl(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) p ^= a;
         a = gf_dbl(a);
      end
      return p;
   endfunction

   function automatic logic [7:0] gf_inv(input logic [7:0] x);
      logic [7:0] r;
      r = 8'h00;
      for (int c = 1; c < 256; c++)
         if (gf_mul(x, 8'(c)) == 8'h01) r = 8'(c);
      return r;
   endfunction

   logic [7:0] fwd_box [256];
   logic [7:0] rev_box [256];

   initial begin
      logic [7:0] b, s;
      for (int i = 0; i < 256; i++) begin
         b = gf_inv(8'(i));
         s = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]} ^ {b[3:0], b[7:4]}
             ^ 8'h63;
         fwd_box[i] = s;
         rev_box[s] = 8'(i);
      end
   end

   function automatic int key_words();
      return klen_reg == KLEN_128 ? 4 : (klen_reg == KLEN_192 ? 6 : 8);
   endfunction

   function automatic logic [31:0] sub_bytes_word(input logic [31:0] w);
      return {fwd_box[w[31:24]], fwd_box[w[23:16]], fwd_box[w[15:8]], fwd_box[w[7:0]]};
   endfunction

   task automatic build_schedule();
      int nk;
      logic [31:0] t;
      logic [7:0] rc;
      nk = key_words();
      rc = 8'h01;
      for (int i = 0; i < nk; i++)
         sched[i] = (i % 2) ? key_reg[i / 2][31:0] : key_reg[i / 2][63:32];
      for (int i = nk; i < 4 * (nk + 7) && i < 60; i++) begin
         t = sched[i - 1];
         if (i % nk == 0) begin
            t = sub_bytes_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
            rc = gf_dbl(rc);
         end else if (nk > 6 && i % nk == 4) begin
            t = sub_bytes_word(t);
         end
         sched[i] = sched[i - nk] ^ t;
      end
      sched_valid = 1'b1;
   endtask

   // state byte k sits at bits 127-8k
   function automatic logic [127:0] add_key(input logic [127:0] s, input int r);
      return s ^ {sched[4 * r], sched[4 * r + 1], sched[4 * r + 2], sched[4 * r + 3]};
   endfunction

   function automatic logic [127:0] shift_sub(input logic [127:0] s, input bit inv);
      logic [7:0] a [16];
      logic [127:0] o;
      int src;
      for (int k = 0; k < 16; k++) a[k] = s[127 - 8 * k -: 8];
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) begin
            src = inv ? ((c + 4 - r) % 4) : ((c + r) % 4);
            o[127 - 8 * (4 * c + r) -: 8] = inv ? rev_box[a[4 * src + r]]
                                                : fwd_box[a[4 * src + r]];
         end
      return o;
   endfunction

   function automatic logic [127:0] mix(input logic [127:0] s, input bit inv);
      logic [7:0] m [4];
      logic [7:0] v;
      logic [127:0] o;
      if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
      else m = '{8'd2, 8'd3, 8'd1, 8'd1};
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) begin
            v = 8'h00;
            for (int k = 0; k < 4; k++)
               v ^= gf_mul(m[(k + 4 - r) % 4], s[127 - 8 * (4 * c + k) -: 8]);
            o[127 - 8 * (4 * c + r) -: 8] = v;
         end
      return o;
   endfunction

   task automatic predict_block(input logic fn, input logic [127:0] blk);
      int nr;
      logic [127:0] s;
      if (!sched_valid) build_schedule();
      nr = key_words() + 6;
      s = blk;
      if (fn == FUNC_ENC) begin
         s = add_key(s, 0);
         for (int r = 1; r <= nr; r++) begin
            s = shift_sub(s, 1'b0);
            if (r != nr) s = mix(s, 1'b0);
            s = add_key(s, r);
         end
      end else begin
         s = add_key(s, nr);
         for (int r = nr; r >= 1; r--) begin
            s = shift_sub(s, 1'b1);
            s = add_key(s, r - 1);
            if (r != 1) s = mix(s, 1'b1);
         end
      end
      expected_blocks.push_back(s);
   endtask

   // result checker
   always @(posedge clock) begin
      logic [127:0] want;
      if (!reset && rsp_valid) begin
         if (expected_blocks.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result %h %h", rsp_result_hi, rsp_result_lo);
         end else begin
            want = expected_blocks.pop_front();
            if (want[127:64] !== rsp_result_hi || want[63:0] !== rsp_result_lo) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h %h actual %h %h",
                           want[127:64], want[63:0], rsp_result_hi, rsp_result_lo);
            end
         end
      end
   end

   // watchdog on cycles without any accepted transaction or result
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || (csr_valid && csr_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   int burst_left;

   // start stays high inside a burst; the next transaction follows at the accepting edge
   task automatic send_block(input logic fn, input logic [63:0] hi, input logic [63:0] lo);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap = $urandom_range(0, 40);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start <= 1'b1;
      req_func <= fn;
      req_block_hi <= hi;
      req_block_lo <= lo;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_block(fn, {hi, lo});
   endtask

   task automatic drain();
      start <= 1'b0;
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (130) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx < CSR_KLEN) key_reg[idx[1:0]] = val;
      else klen_reg = val[1:0];
      sched_valid = 1'b0;
   endtask

   task automatic set_key(input logic [1:0] kl, input logic [255:0] k);
      drain();
      write_csr(CSR_KEY0, k[255:192]);
      write_csr(CSR_KEY1, k[191:128]);
      write_csr(CSR_KEY2, k[127:64]);
      write_csr(CSR_KEY3, k[63:0]);
      write_csr(CSR_KLEN, {62'd0, kl});
      csr_valid <= 1'b0;
   endtask

   function automatic logic [63:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   task automatic test_reset_key();
      send_block(FUNC_ENC, 64'h0, 64'h0);
      send_block(FUNC_DEC, 64'h0, 64'h0);
   endtask

   task automatic test_known_vectors();
      logic [255:0] k;
      k = 256'h000102030405060708090a0b0c0d0e0f101112131415161718191a1b1c1d1e1f;
      set_key(KLEN_128, k);
      send_block(FUNC_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
      send_block(FUNC_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
      set_key(KLEN_192, k);
      send_block(FUNC_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
      send_block(FUNC_DEC, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
      set_key(KLEN_256, k);
      send_block(FUNC_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
      send_block(FUNC_DEC, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
   endtask

   task automatic test_extremes();
      set_key(KLEN_SAT, {256{1'b1}});
      send_block(FUNC_ENC, '1, '1);
      send_block(FUNC_DEC, '1, '1);
      send_block(FUNC_ENC, 64'h0, 64'h0);
      set_key(KLEN_128, '0);
      send_block(FUNC_DEC, '1, 64'h0);
      send_block(FUNC_ENC, 64'h0, '1);
   endtask

   task automatic test_random_keys();
      logic [1:0] kl;
      for (int p = 0; p < 15; p++) begin
         kl = 2'($urandom_range(0, 3));
         set_key(kl, {rnd64(), rnd64(), rnd64(), rnd64()});
         for (int i = 0; i < 30; i++) send_block(1'($urandom), rnd64(), rnd64());
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_func = FUNC_ENC;
      req_block_hi = '0;
      req_block_lo = '0;
      csr_valid = 1'b0;
      csr_index = CSR_KEY0;
      csr_data = '0;
      burst_left = 0;
      key_reg = '{default: '0};
      klen_reg = KLEN_128;
      sched_valid = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_key();
      test_known_vectors();
      test_extremes();
      test_random_keys();
      drain();
      if (mismatches == 0 && expected_blocks.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/aes_pkg.sv
hw/rtl/aes_ctrl.sv
hw/rtl/aes_datapath.sv
hw/rtl/aes_block_cipher.sv
tb/tb_top.sv
